// File: sv/dnms_pkg.sv
// Shared types and constants for the detection decode and NMS core.
package dnms_pkg;

   localparam int MAX_BOXES   = 64;
   localparam int NUM_CLASSES = 1;
   localparam int MAX_ANCHORS = 32768;
   localparam int ADDR_W      = 6;
   localparam int CNT_W       = 7;

   localparam logic [1:0] CSR_CONF_THR = 2'd0;
   localparam logic [1:0] CSR_NMS_THR  = 2'd1;
   localparam logic [1:0] CSR_NET_W    = 2'd2;
   localparam logic [1:0] CSR_NET_H    = 2'd3;

   typedef struct packed {
      logic [14:0]        anchor_index;
      logic [3:0]         class_id;
      logic signed [15:0] ctr_x;
      logic signed [15:0] ctr_y;
      logic signed [15:0] box_w;
      logic signed [15:0] box_h;
      logic [15:0]        objectness;
      logic [15:0]        class_score;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic [14:0] kept_anchor;
      logic [3:0]  kept_class;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] confidence;
      logic        empty_res;
      logic        overflow;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] width;
      logic [15:0] height;
      logic [14:0] anchor;
      logic [3:0]  cls;
      logic [15:0] conf;
   } entry_type;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] width;
      logic [15:0] height;
      logic        ok;
   } dec_type;

endpackage

// File: sv/dnms_mul.sv
// Shared 17x17 unsigned multiplier with registered product.
module dnms_mul (
   input  logic        clock,
   input  logic [16:0] mul_a,
   input  logic [16:0] mul_b,
   output logic [33:0] prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end
endmodule

// File: sv/dnms_decode.sv
// Center/size to clipped corner box conversion with minimum size check.
module dnms_decode (
   input  dnms_pkg::req_type item,
   input  logic [11:0]       net_w,
   input  logic [11:0]       net_h,
   output dnms_pkg::dec_type dec
);
   import dnms_pkg::*;

   function automatic logic [15:0] clampv(input logic signed [18:0] v, input logic [15:0] hi);
      logic [15:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({3'b000, hi})) begin
         r = hi;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic [15:0]        xl, yl, x0c, x1c, y0c, y1c, wc, hc;
   logic signed [18:0] bx, by, bw, bh, x0, x1, y0, y1, wd, hd;

   always_comb begin
      xl  = {net_w, 4'b0000};
      yl  = {net_h, 4'b0000};
      bx  = 19'(item.ctr_x);
      by  = 19'(item.ctr_y);
      bw  = 19'(item.box_w);
      bh  = 19'(item.box_h);
      // floor half size via arithmetic shift
      x0  = bx - (bw >>> 1);
      y0  = by - (bh >>> 1);
      x1  = x0 + bw;
      y1  = y0 + bh;
      x0c = clampv(x0, xl);
      x1c = clampv(x1, xl);
      y0c = clampv(y0, yl);
      y1c = clampv(y1, yl);
      wd  = $signed({3'b000, x1c}) - $signed({3'b000, x0c});
      hd  = $signed({3'b000, y1c}) - $signed({3'b000, y0c});
      wc  = clampv(wd, xl);
      hc  = clampv(hd, yl);
      dec.left   = x0c;
      dec.top    = y0c;
      dec.width  = wc;
      dec.height = hc;
      dec.ok     = (wc >= 16'd16) && (hc >= 16'd16);
   end
endmodule

// File: sv/detection_decode_and_nms_core.sv
// Top level: box store, insertion sort, per-class greedy NMS sequencer.
//
// Input channel req_*: one anchor/class score item per beat. Each item is
// decoded using the shared multiplier, then, if it qualifies, insertion-sorted
// into a 64-entry box store by descending confidence, with a read and a
// compare step for each stored entry of lower confidence. req_stall is
// high while an item is in work, so the input takes no new item until the
// last one is stored or dropped.
// An item with last_item set starts greedy NMS per class. Each pair test
// runs through the one shared 17x17 multiplier
// (intersection, area, two halves of threshold*union); a full store costs
// up to about 2016 pairs of work. Results leave on rsp_* from an output
// register; one result is held back so the final beat can carry
// last_result. A frame with no survivor yields a single empty_res beat.
// A stalled rsp beat holds; the sequencer waits for the output register and
// the input side stays stalled until the frame's last beat is loaded.
// Synchronous reset returns state, thresholds, net size and output flags to defaults and empties the store.
// csr_* writes take effect at once and belong between frames.
module detection_decode_and_nms_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dnms_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dnms_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import dnms_pkg::*;

   typedef enum logic [16:0] {
      S_IDLE    = 17'h00001,
      S_PROD    = 17'h00002,
      S_CHECK   = 17'h00004,
      S_INS_RD  = 17'h00008,
      S_INS_CMP = 17'h00010,
      S_NI_RD   = 17'h00020,
      S_NI_LAT  = 17'h00040,
      S_AREA    = 17'h00080,
      S_NJ_RD   = 17'h00100,
      S_NJ_LAT  = 17'h00200,
      S_M2      = 17'h00400,
      S_M3      = 17'h00800,
      S_M4      = 17'h01000,
      S_M5      = 17'h02000,
      S_M6      = 17'h04000,
      S_EMIT    = 17'h08000,
      S_FIN     = 17'h10000
   } state_type;

   function automatic logic [16:0] ovl(input logic [16:0] amin, input logic [16:0] amax,
                                       input logic [16:0] bmin, input logic [16:0] bmax);
      logic [16:0] a0, a1, b0, b1, r;
      if (amin > bmin) begin
         a0 = bmin; a1 = bmax; b0 = amin; b1 = amax;
      end else begin
         a0 = amin; a1 = amax; b0 = bmin; b1 = bmax;
      end
      if (a1 < b0) begin
         r = '0;
      end else begin
         r = ((a1 < b1) ? a1 : b1) - b0;
      end
      if (a0 > b0) r = '0; // unreachable after the swap
      return r;
   endfunction

   state_type   state_ff, state_in;
   logic [15:0] conf_thr_ff, conf_thr_in, nms_thr_ff, nms_thr_in;
   logic [11:0] net_w_ff, net_w_in, net_h_ff, net_h_in;
   req_type     item_ff, item_in;
   dec_type     dec_ff, dec_in, dec_w;
   logic [15:0] conf_ff, conf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, k_ff, k_in, i_ff, i_in, j_ff, j_in, km1;
   logic [4:0]  cls_ff, cls_in;
   logic        ovf_ff, ovf_in;
   logic [63:0] keep_ff, keep_in;
   entry_type   bi_ff, bi_in, bj_ff, bj_in, rd_ff, wr_data, new_entry;
   logic [31:0] area_ff, area_in, inter_ff, inter_in, lo_ff, lo_in;
   logic [32:0] uni_ff, uni_in;
   rsp_type     pend_ff, pend_in, rsp_ff, rsp_in, cand;
   logic        pend_vld_ff, pend_vld_in, rsp_vld_ff, rsp_vld_in;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic        mem_we, out_free, hit, supp;
   logic [16:0] mul_a, mul_b, ox, oy;
   logic [33:0] mul_q;
   entry_type   mem_ff [64];
   state_type   frame_next;

   dnms_decode u_decode (
      .item  (item_ff),
      .net_w (net_w_ff),
      .net_h (net_h_ff),
      .dec   (dec_w)
   );

   dnms_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_q)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_vld_ff || !rsp_stall;

   always_comb begin
      new_entry.left   = dec_ff.left;
      new_entry.top    = dec_ff.top;
      new_entry.width  = dec_ff.width;
      new_entry.height = dec_ff.height;
      new_entry.anchor = item_ff.anchor_index;
      new_entry.cls    = item_ff.class_id;
      new_entry.conf   = conf_ff;

      cand.kept_anchor = bi_ff.anchor;
      cand.kept_class  = bi_ff.cls;
      cand.left        = bi_ff.left;
      cand.top         = bi_ff.top;
      cand.width       = bi_ff.width;
      cand.height      = bi_ff.height;
      cand.confidence  = bi_ff.conf;
      cand.empty_res   = 1'b0;
      cand.overflow    = ovf_ff;
      cand.last_result = 1'b0;

      frame_next = item_ff.last_item ? S_NI_RD : S_IDLE;
      km1 = k_ff - 1'b1;
      hit = ({1'b0, item_ff.class_id} < 5'(NUM_CLASSES))
         && ({1'b0, item_ff.anchor_index} < 16'(MAX_ANCHORS))
         && (item_ff.objectness > conf_thr_ff)
         && (mul_q[31:0] > {conf_thr_ff, 16'h0000})
         && dec_ff.ok;
      ox = ovl({1'b0, bi_ff.left}, 17'(bi_ff.left) + 17'(bi_ff.width),
               {1'b0, rd_ff.left}, 17'(rd_ff.left) + 17'(rd_ff.width));
      oy = ovl({1'b0, bi_ff.top}, 17'(bi_ff.top) + 17'(bi_ff.height),
               {1'b0, rd_ff.top}, 17'(rd_ff.top) + 17'(rd_ff.height));
      // suppressed when inter*2^16 > thr*union, union split in two halves
      supp = (uni_ff != '0)
          && ({2'b00, inter_ff, 16'h0000} > ({mul_q, 16'h0000} + {18'd0, lo_ff}));

      state_in    = state_ff;
      conf_thr_in = conf_thr_ff;
      nms_thr_in  = nms_thr_ff;
      net_w_in    = net_w_ff;
      net_h_in    = net_h_ff;
      item_in     = item_ff;
      dec_in      = dec_ff;
      conf_in     = conf_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      cls_in      = cls_ff;
      ovf_in      = ovf_ff;
      keep_in     = keep_ff;
      bi_in       = bi_ff;
      bj_in       = bj_ff;
      area_in     = area_ff;
      inter_in    = inter_ff;
      lo_in       = lo_ff;
      uni_in      = uni_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      mem_we      = 1'b0;
      wr_addr     = k_ff[ADDR_W-1:0];
      wr_data     = new_entry;
      rd_addr     = '0;
      mul_a       = '0;
      mul_b       = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_CONF_THR: conf_thr_in = csr_wdata;
            CSR_NMS_THR:  nms_thr_in  = csr_wdata;
            CSR_NET_W:    net_w_in    = csr_wdata[11:0];
            CSR_NET_H:    net_h_in    = csr_wdata[11:0];
            default:      conf_thr_in = conf_thr_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            mul_a    = {1'b0, item_ff.objectness};
            mul_b    = {1'b0, item_ff.class_score};
            dec_in   = dec_w;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            conf_in = mul_q[31:16];
            cls_in  = '0;
            i_in    = '0;
            if (hit && cnt_ff == CNT_W'(MAX_BOXES)) begin
               ovf_in   = 1'b1;
               state_in = frame_next;
            end else if (hit) begin
               k_in     = cnt_ff;
               state_in = S_INS_RD;
            end else begin
               state_in = frame_next;
            end
         end
         S_INS_RD: begin
            if (k_ff == '0) begin
               mem_we   = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = frame_next;
            end else begin
               rd_addr  = km1[ADDR_W-1:0];
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            mem_we = 1'b1;
            if (rd_ff.conf < conf_ff) begin
               // shift the lower-confidence entry up one slot
               wr_data  = rd_ff;
               k_in     = km1;
               state_in = S_INS_RD;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = frame_next;
            end
         end
         S_NI_RD: begin
            if (i_ff == cnt_ff) begin
               if (cls_ff == 5'(NUM_CLASSES - 1)) begin
                  state_in = S_FIN;
               end else begin
                  cls_in = cls_ff + 1'b1;
                  i_in   = '0;
               end
            end else begin
               rd_addr  = i_ff[ADDR_W-1:0];
               state_in = S_NI_LAT;
            end
         end
         S_NI_LAT: begin
            bi_in = rd_ff;
            mul_a = {1'b0, rd_ff.width};
            mul_b = {1'b0, rd_ff.height};
            if ({1'b0, rd_ff.cls} != cls_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_NI_RD;
            end else begin
               j_in     = '0;
               state_in = S_AREA;
            end
         end
         S_AREA: begin
            area_in  = mul_q[31:0];
            state_in = S_NJ_RD;
         end
         S_NJ_RD: begin
            if (j_ff == i_ff) begin
               state_in = S_EMIT;
            end else if (!keep_ff[j_ff[ADDR_W-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else begin
               rd_addr  = j_ff[ADDR_W-1:0];
               state_in = S_NJ_LAT;
            end
         end
         S_NJ_LAT: begin
            bj_in = rd_ff;
            if ({1'b0, rd_ff.cls} != cls_ff) begin
               j_in     = j_ff + 1'b1;
               state_in = S_NJ_RD;
            end else begin
               mul_a    = ox;
               mul_b    = oy;
               state_in = S_M2;
            end
         end
         S_M2: begin
            inter_in = mul_q[31:0];
            mul_a    = {1'b0, bj_ff.width};
            mul_b    = {1'b0, bj_ff.height};
            state_in = S_M3;
         end
         S_M3: begin
            uni_in   = {1'b0, area_ff} + {1'b0, mul_q[31:0]} - {1'b0, inter_ff};
            state_in = S_M4;
         end
         S_M4: begin
            mul_a    = {1'b0, nms_thr_ff};
            mul_b    = {1'b0, uni_ff[15:0]};
            state_in = S_M5;
         end
         S_M5: begin
            lo_in    = mul_q[31:0];
            mul_a    = {1'b0, nms_thr_ff};
            mul_b    = uni_ff[32:16];
            state_in = S_M6;
         end
         S_M6: begin
            if (supp) begin
               i_in     = i_ff + 1'b1;
               state_in = S_NI_RD;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_NJ_RD;
            end
         end
         S_EMIT: begin
            // hold one result back so the frame's final beat can be flagged
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  rsp_in     = pend_ff;
                  rsp_vld_in = 1'b1;
               end
               pend_in     = cand;
               pend_vld_in = 1'b1;
               keep_in     = keep_ff | (64'd1 << i_ff[ADDR_W-1:0]);
               i_in        = i_ff + 1'b1;
               state_in    = S_NI_RD;
            end
         end
         S_FIN: begin
            if (out_free) begin
               if (pend_vld_ff) begin
                  rsp_in = pend_ff;
               end else begin
                  rsp_in          = '0;
                  rsp_in.empty_res = 1'b1;
                  rsp_in.overflow  = ovf_ff;
               end
               rsp_in.last_result = 1'b1;
               rsp_vld_in  = 1'b1;
               pend_vld_in = 1'b0;
               cnt_in      = '0;
               keep_in     = '0;
               ovf_in      = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         conf_thr_ff <= 16'd32768;
         nms_thr_ff  <= 16'd29491;
         net_w_ff    <= 12'd640;
         net_h_ff    <= 12'd640;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         keep_ff     <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         conf_thr_ff <= conf_thr_in;
         nms_thr_ff  <= nms_thr_in;
         net_w_ff    <= net_w_in;
         net_h_ff    <= net_h_in;
         cnt_ff      <= cnt_in;
         ovf_ff      <= ovf_in;
         keep_ff     <= keep_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      dec_ff   <= dec_in;
      conf_ff  <= conf_in;
      k_ff     <= k_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      cls_ff   <= cls_in;
      bi_ff    <= bi_in;
      bj_ff    <= bj_in;
      area_ff  <= area_in;
      inter_ff <= inter_in;
      lo_ff    <= lo_in;
      uni_ff   <= uni_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BOXES))
      else $error("box count past capacity");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.empty_res) |->
         (rsp_data.kept_anchor == '0 && rsp_data.confidence == '0 &&
          rsp_data.width == '0 && rsp_data.last_result))
      else $error("empty beat carries box data");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && out_free) |=>
         (cnt_ff == '0 && keep_ff == '0 && !ovf_ff && state_ff == S_IDLE))
      else $error("frame state not cleared at end of frame");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_vld_ff)
      else $error("held-back result left over between frames");

endmodule

// File: bench/testbench.sv
// Testbench for the detection decode and NMS core: directed and random frames against a box predictor.
`timescale 1ns / 100ps

module testbench;
   import dnms_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_CONF_THR;
   logic [15:0] csr_wdata = '0;

   detection_decode_and_nms_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [15:0] thr_conf = 16'd32768;
   logic [15:0] thr_nms  = 16'd29491;
   logic [11:0] lim_w    = 12'd640;
   logic [11:0] lim_h    = 12'd640;
   entry_type   boxes [0:MAX_BOXES-1];
   int          nboxes = 0;
   logic        dropped = 1'b0;

   rsp_type     pending_boxes [$];
   int          errors = 0;
   int          send_idle = 0;
   int          stall_pct = 0;
   int          hold_len = 0;
   int          held = 0;

   function automatic int clip(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic overlaps(entry_type a, entry_type b);
      longint ax1, bx1, ay1, by1, ox, oy, inter, uni;
      ax1 = a.left + a.width;  bx1 = b.left + b.width;
      ay1 = a.top + a.height;  by1 = b.top + b.height;
      ox = ((ax1 < bx1) ? ax1 : bx1) - ((a.left > b.left) ? a.left : b.left);
      oy = ((ay1 < by1) ? ay1 : by1) - ((a.top > b.top) ? a.top : b.top);
      if (ox < 0) ox = 0;
      if (oy < 0) oy = 0;
      inter = ox * oy;
      uni = longint'(a.width) * a.height + longint'(b.width) * b.height - inter;
      if (uni == 0) return 1'b0;
      return (inter << 16) > longint'(thr_nms) * uni;
   endfunction

   task automatic predict_item(req_type it);
      logic [31:0] prod;
      int x0, y0, x1, y1, w, h, xl, yl, pos;
      entry_type e;
      logic [MAX_BOXES-1:0] kept;
      logic ok;
      int nout;
      rsp_type r;
      prod = it.objectness * it.class_score;
      if (int'(it.class_id) < NUM_CLASSES && int'(it.anchor_index) < MAX_ANCHORS &&
          it.objectness > thr_conf && prod > {thr_conf, 16'h0}) begin
         xl = int'(lim_w) * 16;
         yl = int'(lim_h) * 16;
         x0 = int'(it.ctr_x) - (int'(it.box_w) >>> 1);
         y0 = int'(it.ctr_y) - (int'(it.box_h) >>> 1);
         x1 = x0 + int'(it.box_w);
         y1 = y0 + int'(it.box_h);
         x0 = clip(x0, xl); x1 = clip(x1, xl);
         y0 = clip(y0, yl); y1 = clip(y1, yl);
         w = clip(x1 - x0, xl);
         h = clip(y1 - y0, yl);
         if (w >= 16 && h >= 16) begin
            if (nboxes >= MAX_BOXES) dropped = 1'b1;
            else begin
               e.left = 16'(x0); e.top = 16'(y0); e.width = 16'(w); e.height = 16'(h);
               e.anchor = it.anchor_index; e.cls = it.class_id; e.conf = prod[31:16];
               pos = nboxes;
               while (pos > 0 && boxes[pos-1].conf < e.conf) begin
                  boxes[pos] = boxes[pos-1];
                  pos--;
               end
               boxes[pos] = e;
               nboxes++;
            end
         end
      end
      if (!it.last_item) return;
      kept = '0;
      nout = 0;
      for (int c = 0; c < NUM_CLASSES; c++)
         for (int i = 0; i < nboxes; i++) begin
            if (int'(boxes[i].cls) != c) continue;
            ok = 1'b1;
            for (int j = 0; j < i; j++)
               if (kept[j] && boxes[j].cls == boxes[i].cls && overlaps(boxes[i], boxes[j]))
                  ok = 1'b0;
            if (!ok) continue;
            kept[i] = 1'b1;
            r = '0;
            r.kept_anchor = boxes[i].anchor; r.kept_class = boxes[i].cls;
            r.left = boxes[i].left; r.top = boxes[i].top;
            r.width = boxes[i].width; r.height = boxes[i].height;
            r.confidence = boxes[i].conf; r.overflow = dropped;
            pending_boxes = {pending_boxes, r};
            nout++;
         end
      if (nout == 0) begin
         r = '0;
         r.empty_res = 1'b1;
         r.overflow = dropped;
         pending_boxes = {pending_boxes, r};
      end
      pending_boxes[pending_boxes.size()-1].last_result = 1'b1;
      nboxes = 0;
      dropped = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_boxes.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_boxes.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
               errors++;
            end
         end
      end
   end

   // receiver stall; a long hold-off is counted here
   always @(posedge clock) begin
      if (held < hold_len) begin
         rsp_stall <= 1'b1;
         held <= held + 1;
      end else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_item(req_type it);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(it);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CONF_THR: thr_conf = val;
         CSR_NMS_THR:  thr_nms = val;
         CSR_NET_W:    lim_w = val[11:0];
         default:      lim_h = val[11:0];
      endcase
      @(posedge clock);
   endtask

   function automatic req_type make_item(bit last);
      req_type it;
      it = '0;
      it.anchor_index = 15'($urandom);
      it.class_id = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd0;
      it.ctr_x = 16'($urandom_range(10239));
      it.ctr_y = 16'($urandom_range(10239));
      it.box_w = 16'($urandom_range(3000) + 8);
      it.box_h = 16'($urandom_range(3000) + 8);
      if ($urandom_range(19) == 0) it.ctr_x = 16'($urandom);
      if ($urandom_range(19) == 0) it.box_w = 16'($urandom);
      if ($urandom_range(19) == 0) it.box_h = 16'($urandom);
      it.objectness = 16'($urandom_range(65535, 40000));
      it.class_score = 16'($urandom_range(65535, 45000));
      if ($urandom_range(7) == 0) it.objectness = 16'($urandom);
      if ($urandom_range(7) == 0) it.class_score = 16'($urandom);
      it.last_item = last;
      return it;
   endfunction

   function automatic req_type box_item(int a, int x, int y, int w, int h, int o, bit last);
      req_type it;
      it = '0;
      it.anchor_index = 15'(a); it.ctr_x = 16'(x); it.ctr_y = 16'(y);
      it.box_w = 16'(w); it.box_h = 16'(h); it.objectness = 16'(o);
      it.class_score = 16'hFFFF;
      it.last_item = last;
      return it;
   endfunction

   task automatic test_directed;
      send_item(box_item(0, 0, 0, 0, 0, 0, 1));                       // empty frame
      send_item(box_item(32767, 1600, 1600, 320, 320, 65535, 0));
      send_item(box_item(1, 1600, 1600, 320, 320, 60000, 0));         // suppressed twin
      send_item(box_item(2, 1920, 1600, 320, 320, 60000, 0));         // touching edge
      send_item(box_item(3, 1600, 1600, 320, 320, 60000, 0));         // equal confidence
      send_item(box_item(4, -32768, -32768, 32767, 32767, 65535, 0));
      send_item(box_item(5, 32767, 32767, 32767, 32767, 65535, 0));   // clipped away
      send_item(box_item(6, 100, 100, -32768, 200, 65535, 0));        // negative size
      send_item(box_item(7, 100, 100, 15, 200, 65535, 0));            // under a pixel
      send_item(box_item(8, 100, 100, 17, 17, 32768, 0));            // obj at threshold
      send_item(box_item(9, 100, 100, 40, 40, 32769, 0));             // product just over threshold
      begin
         req_type it;
         it = box_item(10, 500, 500, 64, 64, 65535, 0);
         it.class_id = 4'hF;                                          // class out of range
         send_item(it);
         it.class_id = 4'd0; it.class_score = 16'd0;
         send_item(it);
      end
      send_item(box_item(11, 800, 800, 100, 100, 65535, 1));
      drain();
   endtask

   task automatic run_frames(int nitems, int maxlen);
      int left, len;
      left = nitems;
      while (left > 0) begin
         len = $urandom_range(maxlen, 1);
         if (len > left) len = left;
         for (int k = 0; k < len; k++) send_item(make_item(k == len - 1));
         left -= len;
      end
   endtask

   task automatic test_overflow;
      // overfill the store, then hold off the receiver through the frame's results
      for (int k = 0; k < 70; k++) begin
         if (k == 69) hold_len = 3000;
         send_item(box_item(k, 320 + 40 * k, 640, 24, 24,
                            int'($urandom_range(65535, 50000)), k == 69));
      end
      // next frame waits at the input while the results are held
      send_item(box_item(70, 800, 800, 100, 100, 65535, 1));
      drain();
   endtask

   task automatic test_configs;
      write_csr(CSR_CONF_THR, 16'd0);
      write_csr(CSR_NMS_THR, 16'd0);
      write_csr(CSR_NET_W, 16'd1);
      write_csr(CSR_NET_H, 16'd4095);
      run_frames(30, 6);
      drain();
      write_csr(CSR_CONF_THR, 16'hFFFF);
      write_csr(CSR_NMS_THR, 16'hFFFF);
      write_csr(CSR_NET_W, 16'd4095);
      write_csr(CSR_NET_H, 16'd1);
      run_frames(20, 5);
      send_item(box_item(0, 0, 0, 0, 0, 0, 1));
      drain();
      write_csr(CSR_CONF_THR, 16'd20000);
      write_csr(CSR_NMS_THR, 16'd32768);
      write_csr(CSR_NET_W, 16'd320);
      write_csr(CSR_NET_H, 16'd480);
      run_frames(40, 10);
      drain();
      write_csr(CSR_CONF_THR, 16'd32768);
      write_csr(CSR_NMS_THR, 16'd29491);
      write_csr(CSR_NET_W, 16'd640);
      write_csr(CSR_NET_H, 16'd640);
   endtask

   task automatic test_random;
      send_idle = 0;  stall_pct = 0;  run_frames(60, 12);
      send_idle = 49; stall_pct = 0;  run_frames(60, 12);
      drain();                       // sender waits out every result
      send_idle = 0;  stall_pct = 49; run_frames(60, 12);
      send_idle = 14; stall_pct = 14; run_frames(60, 12);
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_configs();
      test_random();
      if (errors == 0 && pending_boxes.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: detection_decode_and_nms_core.f
sv/dnms_pkg.sv
sv/dnms_mul.sv
sv/dnms_decode.sv
sv/detection_decode_and_nms_core.sv
bench/testbench.sv
